// ===== sv/matrix_vertex_transform_unit_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix vertex transform unit
// Checks sampled on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VERTEX_TRANSFORM_UNIT_CORE_MACROS_SVH
`define MATRIX_VERTEX_TRANSFORM_UNIT_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MVTU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define MVTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mvtu_pkg.sv =====
// ----------------------------------------------------------------------------
// mvtu_pkg
// Shared widths, opcodes, sequencer states and lane structs.
// ----------------------------------------------------------------------------
package mvtu_pkg;

	localparam int DATA_W  = 32;            // Q16.16 element width
	localparam int FRAC_W  = 16;            // fraction bits
	localparam int LANES   = 4;             // one lane per matrix row
	localparam int K_W     = $clog2(LANES); // row / column / term index
	localparam int PROD_W  = 2 * DATA_W;
	localparam int SHP_W   = PROD_W - FRAC_W;   // product after floor shift
	localparam int ACC_W   = SHP_W + K_W;       // exact sum of LANES terms

	localparam int S_TDATA_W = 168;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = LANES * DATA_W;
	localparam int M_TUSER_W = 1;

	localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(64'd1 << FRAC_W);
	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [2:0] {
		OP_WR_CUR  = 3'd0,
		OP_WR_STG  = 3'd1,
		OP_COMPOSE = 3'd2,
		OP_XFORM   = 3'd3,
		OP_IDENT   = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} seq_state_t;

	// per-cycle lane control, broadcast to all lanes
	typedef struct packed {
		logic           issue;
		logic           first;
		logic           last;
		logic           compose;
		logic [K_W-1:0] col;
	} lane_ctl_t;

	// finished dot product from one lane
	typedef struct packed {
		logic                     vld;
		logic                     compose;
		logic [K_W-1:0]           col;
		logic                     clip;
		logic signed [DATA_W-1:0] value;
	} lane_res_t;

endpackage

// ===== sv/matrix_vertex_transform_unit_core.sv =====
// ----------------------------------------------------------------------------
// matrix_vertex_transform_unit_core
// 4x4 column-major Q16.16 matrix unit: element writes, identity, compose,
// vertex transform. Four row lanes share the dot products; a merge stage
// packs the transform result.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: opcode; s_tdata: index, value, x, y, z, w
// m_*       out  m_tvalid/m_tready  m_tdata: out_x..out_w; m_tuser: saturated
//
// Sequencing: element write and identity complete at accept and leave the
// block ready. A transform issues its terms through each lane's single
// multiplier, drains the multiplier and accumulator stages, then passes a
// finish state before the next accept; its result reaches m_* through the
// lane and merge registers. A compose issues 4 columns x 4 terms per lane,
// then drains and writes back. Each lane's multiplier is reused once per term.
// Reset: current matrix returns to identity, staged matrix to zero, output
// empty. A waiting result does not block writes or compose; a transform
// holds at its first issue cycle while the previous result is still unread.
// ----------------------------------------------------------------------------
`include "matrix_vertex_transform_unit_core_macros.svh"

module matrix_vertex_transform_unit_core
	import mvtu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // element_index[3:0], element_value[35:4],
	                                       // in_x[67:36], in_y[99:68], in_z[131:100],
	                                       // in_w[163:132], zero pad
	input  logic [S_TUSER_W-1:0] s_tuser,  // opcode[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64],
	                                       // out_w[127:96]
	output logic [M_TUSER_W-1:0] m_tuser   // saturated[0]
);

	// input field offsets in s_tdata
	localparam int IDX_W   = 2 * K_W;
	localparam int IDX_LSB = 0;
	localparam int VAL_LSB = IDX_LSB + IDX_W;
	localparam int VTX_LSB = VAL_LSB + DATA_W;
	localparam int CNT_W   = 2 * K_W;   // column and term of one issue cycle

	// ------------------------------------------------------------------
	// decoded input item
	// ------------------------------------------------------------------
	opcode_t                  op;
	logic [IDX_W-1:0]         idx;
	logic [K_W-1:0]           idx_row;
	logic [K_W-1:0]           idx_col;
	logic signed [DATA_W-1:0] value;
	logic                     accept;

	assign op      = opcode_t'(s_tuser);
	assign idx     = s_tdata[IDX_LSB +: IDX_W];
	assign idx_row = idx[K_W-1:0];           // element index = row + 4*column
	assign idx_col = idx[IDX_W-1:K_W];
	assign value   = s_tdata[VAL_LSB +: DATA_W];
	assign accept  = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// state: current matrix by [row][col], staged matrix by element index,
	// compose scratch by [row][col], latched vertex
	// ------------------------------------------------------------------
	logic signed [DATA_W-1:0] cur_q [LANES][LANES];
	logic signed [DATA_W-1:0] tmp_q [LANES][LANES];
	logic signed [DATA_W-1:0] stg_q [LANES*LANES];
	logic signed [DATA_W-1:0] vtx_q [LANES];
	logic                     cmp_q;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	seq_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] cnt_last;
	logic             out_busy;
	logic             go;
	logic             commit;
	lane_ctl_t        ctl;

	// compose walks all columns, transform only column zero
	assign cnt_last = cmp_q ? {CNT_W{1'b1}} : CNT_W'(LANES - 1);
	// a transform may not start while the previous result is still unread
	assign go       = cmp_q || !out_busy;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (accept && (op == OP_COMPOSE || op == OP_XFORM)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (go) begin
					if (cnt_q == cnt_last) begin
						cnt_d   = '0;
						state_d = ST_DRAIN;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				// drain the multiplier stage, then the accumulator stage
				cnt_d = cnt_q + 1'b1;
				if (cnt_q[0]) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cnt_d   = '0;
				state_d = ST_IDLE;
			end
			default: begin
				cnt_d   = '0;
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = (state_q == ST_IDLE);
		commit      = (state_q == ST_FINISH) && cmp_q;
		ctl.issue   = (state_q == ST_RUN) && go;
		ctl.first   = (cnt_q[K_W-1:0] == '0);
		ctl.last    = (cnt_q[K_W-1:0] == {K_W{1'b1}});
		ctl.compose = cmp_q;
		ctl.col     = cnt_q[CNT_W-1:K_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cmp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (accept) begin
				cmp_q <= (op == OP_COMPOSE);
			end
		end
	end

	// ------------------------------------------------------------------
	// matrix storage
	// ------------------------------------------------------------------
	lane_res_t [LANES-1:0] lane_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < LANES; r++) begin
				for (int c = 0; c < LANES; c++) begin
					cur_q[r][c] <= (r == c) ? Q_ONE : '0;
				end
			end
			for (int i = 0; i < LANES*LANES; i++) begin
				stg_q[i] <= '0;
			end
		end else begin
			if (commit) begin
				cur_q <= tmp_q;
			end else if (accept && op == OP_IDENT) begin
				for (int r = 0; r < LANES; r++) begin
					for (int c = 0; c < LANES; c++) begin
						cur_q[r][c] <= (r == c) ? Q_ONE : '0;
					end
				end
			end else if (accept && op == OP_WR_CUR) begin
				cur_q[idx_row][idx_col] <= value;
			end
			if (accept && op == OP_WR_STG) begin
				stg_q[idx] <= value;
			end
		end
	end

	// compose results collect here until the last column lands
	always_ff @(posedge clk) begin
		for (int r = 0; r < LANES; r++) begin
			if (lane_res[r].vld && lane_res[r].compose) begin
				tmp_q[r][lane_res[r].col] <= lane_res[r].value;
			end
		end
		if (accept && op == OP_XFORM) begin
			for (int k = 0; k < LANES; k++) begin
				vtx_q[k] <= s_tdata[VTX_LSB + k*DATA_W +: DATA_W];
			end
		end
	end

	// ------------------------------------------------------------------
	// lanes: lane r owns row r; the second operand is broadcast, either
	// staged[term + 4*col] for compose or vertex[term] for transform
	// ------------------------------------------------------------------
	logic signed [DATA_W-1:0] opb;

	assign opb = cmp_q ? stg_q[cnt_q] : vtx_q[cnt_q[K_W-1:0]];

	for (genvar r = 0; r < LANES; r++) begin : g_lane
		mvtu_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.opa    (cur_q[r][cnt_q[K_W-1:0]]),
			.opb    (opb),
			.res    (lane_res[r])
		);
	end

	// ------------------------------------------------------------------
	// merge and output register
	// ------------------------------------------------------------------
	mvtu_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (lane_res),
		.busy     (out_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`MVTU_ASSERT_SAME(a_lanes_in_step, lane_res[0].vld, lane_res[1].vld && lane_res[2].vld && lane_res[3].vld, "lanes finished out of step")
	`MVTU_ASSERT_SAME(a_out_free, lane_res[0].vld && !lane_res[0].compose, !m_tvalid, "transform result arrived while output still full")
	`MVTU_ASSERT_SAME(a_out_source, $rose(m_tvalid), $past(lane_res[0].vld), "output item without lane result")
	`MVTU_ASSERT_NEXT(a_commit_align, lane_res[3].vld && lane_res[3].compose && lane_res[3].col == {K_W{1'b1}}, state_q == ST_FINISH, "compose write-back misaligned with last column")

endmodule

// ===== sv/mvtu_lane.sv =====
// ----------------------------------------------------------------------------
// mvtu_lane
// One row lane: multiply, floor shift, accumulate four terms, saturate.
// ----------------------------------------------------------------------------
module mvtu_lane
	import mvtu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  lane_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] opa,
	input  logic signed [DATA_W-1:0] opb,
	output lane_res_t                res
);

	logic                     vld_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic                     cmp_s1;
	logic [K_W-1:0]           col_s1;
	logic signed [PROD_W-1:0] prod_s1;

	logic                     done_s2;
	logic                     cmp_s2;
	logic [K_W-1:0]           col_s2;
	logic signed [ACC_W-1:0]  acc_s2;

	logic signed [ACC_W-1:0]  term;
	logic [ACC_W-DATA_W:0]    acc_hi;
	logic                     fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= ctl.issue;
			done_s2 <= vld_s1 && last_s1;
		end
	end

	// floor shift is a plain drop of the low fraction bits
	assign term = {{(ACC_W-SHP_W){prod_s1[PROD_W-1]}}, prod_s1[PROD_W-1:FRAC_W]};

	always_ff @(posedge clk) begin
		first_s1 <= ctl.first;
		last_s1  <= ctl.last;
		cmp_s1   <= ctl.compose;
		col_s1   <= ctl.col;
		prod_s1  <= opa * opb;
		cmp_s2   <= cmp_s1;
		col_s2   <= col_s1;
		if (vld_s1) begin
			acc_s2 <= (first_s1 ? '0 : acc_s2) + term;
		end
	end

	// in range when every bit from the sign of the result up agrees
	assign acc_hi = acc_s2[ACC_W-1:DATA_W-1];
	assign fits   = (&acc_hi) || !(|acc_hi);

	always_comb begin
		res.vld     = done_s2;
		res.compose = cmp_s2;
		res.col     = col_s2;
		res.clip    = !fits;
		if (fits) begin
			res.value = acc_s2[DATA_W-1:0];
		end else if (acc_s2[ACC_W-1]) begin
			res.value = Q_MIN;
		end else begin
			res.value = Q_MAX;
		end
	end

endmodule

// ===== sv/mvtu_merge.sv =====
// ----------------------------------------------------------------------------
// mvtu_merge
// Packs the four lane results into one output item and holds it until taken.
// ----------------------------------------------------------------------------
module mvtu_merge
	import mvtu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  lane_res_t [LANES-1:0]    res,
	output logic                     busy,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [M_TDATA_W-1:0]     m_tdata,  // out_x, out_y, out_z, out_w
	output logic [M_TUSER_W-1:0]     m_tuser   // saturated
);

	logic                 valid_q;
	logic [M_TDATA_W-1:0] data_q;
	logic [M_TUSER_W-1:0] user_q;
	logic [M_TDATA_W-1:0] data_d;
	logic                 clip_any;
	logic                 load;

	assign load = res[0].vld && !res[0].compose;

	always_comb begin
		data_d   = '0;
		clip_any = 1'b0;
		for (int r = 0; r < LANES; r++) begin
			data_d[r*DATA_W +: DATA_W] = res[r].value;
			clip_any = clip_any | res[r].clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_d;
			user_q <= M_TUSER_W'(clip_any);
		end
	end

	assign busy     = valid_q;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

// ===== verif/matrix_vertex_transform_unit_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_vertex_transform_unit_core_tb
// Self-checking bench: a short table of directed items (reset identity,
// extreme values, unused opcodes, compose overflow) and then a random mix of
// element writes, compose, identity and vertex transforms. A local Q16.16
// model of both matrices predicts each transform result that has no
// hand-derived value in the table. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module matrix_vertex_transform_unit_core_tb;
	import mvtu_pkg::*;

	// opcodes the block must ignore
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam int          NUM_RANDOM   = 525;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          DIAG_STRIDE  = 5;    // row + 4*col on the diagonal
	localparam logic [31:0] FX_ONE       = 32'h0001_0000;
	localparam logic [31:0] FX_NEG_ONE   = 32'hFFFF_0000;

	typedef struct packed {
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [31:0] vw;
		logic        sat;
	} vertex_out_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  idx;
		logic [31:0] val;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
		logic        fixed;   // want holds a hand-derived result
		vertex_out_t want;
	} stim_row_t;

	localparam int NUM_DIRECTED = 25;
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		// identity after reset passes the extremes through untouched
		'{OP_XFORM, 4'd0, 32'd0, Q_MAX, Q_MIN, 32'd0, 32'hFFFF_FFFF,
			1'b1, '{Q_MAX, Q_MIN, 32'd0, 32'hFFFF_FFFF, 1'b0}},
		'{OP_SPARE_5, 4'd3, 32'hDEAD_BEEF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_SPARE_6, 4'd9, 32'h1234_5678, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_SPARE_7, 4'd15, Q_MIN, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		// spare opcodes left the identity alone
		'{OP_XFORM, 4'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, FX_ONE, FX_NEG_ONE,
			1'b1, '{32'd1, 32'hFFFF_FFFF, FX_ONE, FX_NEG_ONE, 1'b0}},
		'{OP_WR_CUR, 4'd0, Q_MAX, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_WR_CUR, 4'd15, Q_MIN, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		// row 0 clips high, row 3 clips low
		'{OP_XFORM, 4'd0, 32'd0, Q_MAX, 32'd0, 32'd0, Q_MAX,
			1'b1, '{Q_MAX, 32'd0, 32'd0, Q_MIN, 1'b1}},
		'{OP_IDENT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_XFORM, 4'd0, 32'd0, Q_MIN, Q_MAX, 32'h0000_8000, 32'hFFFF_8000,
			1'b1, '{Q_MIN, Q_MAX, 32'h0000_8000, 32'hFFFF_8000, 1'b0}},
		// staged: scale (2, 2, -2) plus x translation of 3.5
		'{OP_WR_STG, 4'd0, 32'h0002_0000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_WR_STG, 4'd5, 32'h0002_0000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_WR_STG, 4'd10, 32'hFFFE_0000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_WR_STG, 4'd15, FX_ONE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_WR_STG, 4'd12, 32'h0003_8000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_COMPOSE, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_XFORM, 4'd0, 32'd0, FX_ONE, FX_ONE, FX_ONE, FX_ONE, 1'b0, '0},
		'{OP_XFORM, 4'd0, 32'd0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0, '0},
		// compose overflow saturates silently
		'{OP_WR_STG, 4'd0, Q_MAX, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_COMPOSE, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_XFORM, 4'd0, 32'd0, FX_ONE, FX_NEG_ONE, FX_ONE, FX_ONE, 1'b0, '0},
		'{OP_WR_CUR, 4'd7, Q_MIN, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_XFORM, 4'd0, 32'd0, 32'd7, Q_MIN, 32'hFFFF_FFFF, Q_MIN, 1'b0, '0},
		'{OP_IDENT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
		'{OP_XFORM, 4'd0, 32'd0, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_F0F0,
			32'hF0F0_0F0F, 1'b0, '0}
	};

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	matrix_vertex_transform_unit_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local copy of both matrices, column-major
	logic signed [DATA_W-1:0] cur_m [16];
	logic signed [DATA_W-1:0] stg_m [16];
	vertex_out_t              pending_vertices [$];
	int                       mismatch_count = 0;
	int                       cycle_count    = 0;
	bit                       sender_burst   = 1'b0;
	bit                       receiver_burst = 1'b0;

	// exact product, floor-shifted back to Q16.16 scale
	function automatic longint scaled_product(logic signed [DATA_W-1:0] a,
	                                          logic signed [DATA_W-1:0] b);
		return (longint'(a) * longint'(b)) >>> FRAC_W;
	endfunction

	function automatic logic [DATA_W-1:0] clip_sum(longint s, inout logic clipped);
		if (s > longint'(Q_MAX)) begin
			clipped = 1'b1;
			return Q_MAX;
		end
		if (s < longint'(Q_MIN)) begin
			clipped = 1'b1;
			return Q_MIN;
		end
		return DATA_W'(s);
	endfunction

	function automatic void load_identity();
		for (int i = 0; i < 16; i++)
			cur_m[i] = (i % DIAG_STRIDE == 0) ? Q_ONE : '0;
	endfunction

	// next matrix state for one item; a transform also yields a vertex
	function automatic void apply_opcode(input stim_row_t row, output logic has_vertex,
	                                     output vertex_out_t vertex);
		logic signed [DATA_W-1:0] product_m [16];
		logic signed [DATA_W-1:0] vin [4];
		logic [DATA_W-1:0]        comp [4];
		longint                   acc;
		logic                     clip;
		logic                     ignored;
		has_vertex = 1'b0;
		vertex     = '0;
		clip       = 1'b0;
		ignored    = 1'b0;
		case (row.op)
			OP_WR_CUR: begin
				cur_m[row.idx] = row.val;
			end
			OP_WR_STG: begin
				stg_m[row.idx] = row.val;
			end
			OP_COMPOSE: begin
				for (int c = 0; c < LANES; c++)
					for (int r = 0; r < LANES; r++) begin
						acc = 0;
						for (int k = 0; k < LANES; k++)
							acc += scaled_product(cur_m[r + LANES * k], stg_m[k + LANES * c]);
						product_m[r + LANES * c] = clip_sum(acc, ignored);
					end
				cur_m = product_m;
			end
			OP_XFORM: begin
				vin = '{row.x, row.y, row.z, row.w};
				for (int r = 0; r < LANES; r++) begin
					acc = 0;
					for (int k = 0; k < LANES; k++)
						acc += scaled_product(cur_m[r + LANES * k], vin[k]);
					comp[r] = clip_sum(acc, clip);
				end
				vertex     = '{comp[0], comp[1], comp[2], comp[3], clip};
				has_vertex = 1'b1;
			end
			OP_IDENT: begin
				load_identity();
			end
			default: ;
		endcase
	endfunction

	// mostly values within +-half_span, some full-range, some extremes
	function automatic logic [31:0] draw_q(logic [31:0] half_span);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return 32'd0;
					3: return FX_ONE;
					default: return FX_NEG_ONE;
				endcase
			end
			default: return $urandom_range(0, 2 * half_span) - half_span;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// one item out on s_*; fields the opcode ignores carry junk
	task automatic send_item(input stim_row_t row);
		int          gap;
		logic        has_vertex;
		vertex_out_t vertex;
		if (row.op != OP_XFORM) begin
			row.x = $urandom;
			row.y = $urandom;
			row.z = $urandom;
			row.w = $urandom;
		end
		if (row.op != OP_WR_CUR && row.op != OP_WR_STG) begin
			row.idx = 4'($urandom);
			row.val = $urandom;
		end
		gap = sender_burst ? 0 : $urandom_range(0, 9);
		if ($urandom_range(0, 39) == 0)
			sender_burst = !sender_burst;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= row.op;
		s_tdata  <= {4'b0, row.w, row.z, row.y, row.x, row.val, row.idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_opcode(row, has_vertex, vertex);
		if (has_vertex)
			pending_vertices.push_back(row.fixed ? row.want : vertex);
	endtask

	// result side: random stalls, with runs of none
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = receiver_burst ? 0 : $urandom_range(0, 9);
			if ($urandom_range(0, 39) == 0)
				receiver_burst = !receiver_burst;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		vertex_out_t got;
		vertex_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tuser[0]};
			if (pending_vertices.size() == 0) begin
				report_mismatch("unexpected vertex, out_x", got.vx, 32'd0);
			end else begin
				want = pending_vertices.pop_front();
				if (got.vx !== want.vx)
					report_mismatch("out_x", got.vx, want.vx);
				if (got.vy !== want.vy)
					report_mismatch("out_y", got.vy, want.vy);
				if (got.vz !== want.vz)
					report_mismatch("out_z", got.vz, want.vz);
				if (got.vw !== want.vw)
					report_mismatch("out_w", got.vw, want.vw);
				if (got.sat !== want.sat)
					report_mismatch("saturated", 32'(got.sat), 32'(want.sat));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("matrix_vertex_transform_unit_core verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int        pick;
		load_identity();
		for (int i = 0; i < 16; i++)
			stg_m[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_item(DIRECTED[i]);

		// transforms dominate; writes keep both matrices moving
		for (int i = 0; i < NUM_RANDOM; i++) begin
			row   = '0;
			pick  = $urandom_range(0, 99);
			row.x = draw_q(32'h03E8_0000);
			row.y = draw_q(32'h03E8_0000);
			row.z = draw_q(32'h03E8_0000);
			row.w = draw_q(32'h03E8_0000);
			row.idx = 4'($urandom_range(0, 15));
			row.val = draw_q(32'h0004_0000);
			if (pick < 45)
				row.op = OP_XFORM;
			else if (pick < 65)
				row.op = OP_WR_CUR;
			else if (pick < 85)
				row.op = OP_WR_STG;
			else if (pick < 91)
				row.op = OP_COMPOSE;
			else if (pick < 95)
				row.op = OP_IDENT;
			else
				row.op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
			send_item(row);
		end
		s_tvalid <= 1'b0;

		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("matrix_vertex_transform_unit_core verification clean");
		else
			$display("matrix_vertex_transform_unit_core verification failed");
		$finish;
	end

endmodule

// ===== matrix_vertex_transform_unit_core.f =====
+incdir+sv
sv/mvtu_pkg.sv
sv/mvtu_lane.sv
sv/mvtu_merge.sv
sv/matrix_vertex_transform_unit_core.sv
verif/matrix_vertex_transform_unit_core_tb.sv
